// ===== design/adsr_pkg.sv =====
// Shared constants, config register codes and control struct for the ADSR envelope.
// Used by every module of the envelope pipeline; depends on nothing else.
`default_nettype none

package adsr_pkg;

  // Default tick counter width.
  localparam int TICK_WIDTH_DEF = 24;

  // Q1.15 value width and the value 1.0.
  localparam int Q_W = 16;
  localparam logic [Q_W-1:0] Q_ONE = 16'h8000;

  // Reset length of every segment, in ticks.
  localparam int LEN_RESET = 100;

  // Config register index width and codes.
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 3'd0,
    CFG_DECAY   = 3'd1,
    CFG_RELEASE = 3'd2,
    CFG_SUSTAIN = 3'd3,
    CFG_GAIN    = 3'd4
  } adsr_cfg_idx_t;

  // Per-beat control that rides along the divider.
  // fixed: env is base as is; otherwise env = base + q (up) or base - ceil (down).
  typedef struct packed {
    logic           down;
    logic           fixed;
    logic [Q_W-1:0] base;
  } adsr_ctl_t;

  // Clamp a Q1.15 register value to 1.0.
  function automatic logic [Q_W-1:0] sat_q(input logic [Q_W-1:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

endpackage

`default_nettype wire

// ===== design/adsr_seg.sv =====
// Input capture and segment decode: picks attack, decay, sustain or release.
// Depends on adsr_pkg; feeds offset, length, span and control to adsr_mul.
`default_nettype none

module adsr_seg #(
  parameter int TICK_WIDTH = adsr_pkg::TICK_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_vld,
  output logic                          in_rdy,
  input  wire logic                     in_released,
  input  wire logic [TICK_WIDTH-1:0]    in_ticks,
  input  wire logic [TICK_WIDTH-1:0]    attack_len,
  input  wire logic [TICK_WIDTH-1:0]    decay_len,
  input  wire logic [TICK_WIDTH-1:0]    release_len,
  input  wire logic [adsr_pkg::Q_W-1:0] sus_lvl,
  output logic                          out_vld,
  input  wire logic                     out_rdy,
  output logic [TICK_WIDTH-1:0]         out_ofs,
  output logic [TICK_WIDTH-1:0]         out_len,
  output logic [adsr_pkg::Q_W-1:0]      out_span,
  output adsr_pkg::adsr_ctl_t           out_ctl
);
  import adsr_pkg::*;

  logic                  cap_vld_r;
  logic                  cap_rel_r;
  logic [TICK_WIDTH-1:0] cap_t_r;
  logic                  dec_vld_r;
  logic [TICK_WIDTH-1:0] ofs_r, ofs_nxt;
  logic [TICK_WIDTH-1:0] len_r, len_nxt;
  logic [Q_W-1:0]        span_r, span_nxt;
  adsr_ctl_t             ctl_r, ctl_nxt;
  logic [TICK_WIDTH:0]   diff;
  logic                  cap_en, dec_en;

  // Advance a stage when it is empty or its beat moves on.
  assign dec_en = !dec_vld_r || out_rdy;
  assign cap_en = !cap_vld_r || dec_en;
  assign in_rdy = cap_en;

  // Capture the input beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_vld_r <= 1'b0;
    end else if (cap_en) begin
      cap_vld_r <= in_vld;
    end
    if (cap_en && in_vld) begin
      cap_rel_r <= in_released;
      cap_t_r   <= in_ticks;
    end
  end

  // Ticks past the end of attack; the top bit flags t below attack.
  assign diff = {1'b0, cap_t_r} - {1'b0, attack_len};

  // Decode the segment into offset, length, span and direction.
  always_comb begin
    ofs_nxt       = '0;
    len_nxt       = '0;
    span_nxt      = '0;
    ctl_nxt.down  = 1'b0;
    ctl_nxt.fixed = 1'b1;
    ctl_nxt.base  = '0;
    if (cap_rel_r) begin
      // Release: sustain down to zero, zero past the end or on empty segment.
      if (!(cap_t_r > release_len || release_len == '0)) begin
        ofs_nxt       = cap_t_r;
        len_nxt       = release_len;
        span_nxt      = sus_lvl;
        ctl_nxt.down  = 1'b1;
        ctl_nxt.fixed = 1'b0;
        ctl_nxt.base  = sus_lvl;
      end
    end else if (!diff[TICK_WIDTH] && diff[TICK_WIDTH-1:0] != '0) begin
      if (diff[TICK_WIDTH-1:0] > decay_len) begin
        // Sustain: hold the level.
        ctl_nxt.base = sus_lvl;
      end else begin
        // Decay: 1.0 down to sustain.
        ofs_nxt       = diff[TICK_WIDTH-1:0];
        len_nxt       = decay_len;
        span_nxt      = Q_ONE - sus_lvl;
        ctl_nxt.down  = 1'b1;
        ctl_nxt.fixed = 1'b0;
        ctl_nxt.base  = Q_ONE;
      end
    end else if (attack_len == '0) begin
      // Empty attack gives its end value.
      ctl_nxt.base = Q_ONE;
    end else begin
      // Attack: zero up to 1.0.
      ofs_nxt       = cap_t_r;
      len_nxt       = attack_len;
      span_nxt      = Q_ONE;
      ctl_nxt.fixed = 1'b0;
    end
  end

  // Hold the decoded beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_vld_r <= 1'b0;
    end else if (dec_en) begin
      dec_vld_r <= cap_vld_r;
    end
    if (dec_en && cap_vld_r) begin
      ofs_r  <= ofs_nxt;
      len_r  <= len_nxt;
      span_r <= span_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  assign out_vld  = dec_vld_r;
  assign out_ofs  = ofs_r;
  assign out_len  = len_r;
  assign out_span = span_r;
  assign out_ctl  = ctl_r;

endmodule

`default_nettype wire

// ===== design/adsr_mul.sv =====
// Product stage: span times offset, the dividend of the segment blend.
// Depends on adsr_pkg; sits between adsr_seg and adsr_div.
`default_nettype none

module adsr_mul #(
  parameter int TICK_WIDTH = adsr_pkg::TICK_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_vld,
  output logic                                     in_rdy,
  input  wire logic [TICK_WIDTH-1:0]               in_ofs,
  input  wire logic [TICK_WIDTH-1:0]               in_len,
  input  wire logic [adsr_pkg::Q_W-1:0]            in_span,
  input  wire adsr_pkg::adsr_ctl_t                 in_ctl,
  output logic                                     out_vld,
  input  wire logic                                out_rdy,
  output logic [adsr_pkg::Q_W+TICK_WIDTH-1:0]      out_prod,
  output logic [TICK_WIDTH-1:0]                    out_len,
  output adsr_pkg::adsr_ctl_t                      out_ctl
);
  import adsr_pkg::*;

  localparam int PW = Q_W + TICK_WIDTH;

  logic                  vld_r;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic [TICK_WIDTH-1:0] len_r;
  adsr_ctl_t             ctl_r;
  logic                  en;

  assign en     = !vld_r || out_rdy;
  assign in_rdy = en;

  // Multiply span by offset at full width.
  assign prod_nxt = PW'(in_span) * PW'(in_ofs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en && in_vld) begin
      prod_r <= prod_nxt;
      len_r  <= in_len;
      ctl_r  <= in_ctl;
    end
  end

  assign out_vld  = vld_r;
  assign out_prod = prod_r;
  assign out_len  = len_r;
  assign out_ctl  = ctl_r;

endmodule

`default_nettype wire

// ===== design/adsr_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, Q_W stages.
// Depends on adsr_pkg; the quotient is known to fit Q_W bits.
`default_nettype none

module adsr_div #(
  parameter int TICK_WIDTH = adsr_pkg::TICK_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_vld,
  output logic                                in_rdy,
  input  wire logic [adsr_pkg::Q_W+TICK_WIDTH-1:0] in_prod,
  input  wire logic [TICK_WIDTH-1:0]          in_len,
  input  wire adsr_pkg::adsr_ctl_t            in_ctl,
  output logic                                out_vld,
  input  wire logic                           out_rdy,
  output logic [adsr_pkg::Q_W-1:0]            out_quo,
  output logic                                out_rem_nz,
  output adsr_pkg::adsr_ctl_t                 out_ctl
);
  import adsr_pkg::*;

  localparam int STEPS = Q_W;

  // Stage boundaries: index 0 is the input, index k+1 the register of stage k.
  logic                  vld_a [0:STEPS];
  logic                  rdy_a [0:STEPS];
  logic [TICK_WIDTH-1:0] rem_a [0:STEPS];
  logic [Q_W-1:0]        wrd_a [0:STEPS];
  logic [TICK_WIDTH-1:0] len_a [0:STEPS];
  adsr_ctl_t             ctl_a [0:STEPS];

  // High part starts as the partial remainder; low part shifts in quotient bits.
  assign vld_a[0]     = in_vld;
  assign in_rdy       = rdy_a[0];
  assign rem_a[0]     = in_prod[Q_W+TICK_WIDTH-1:Q_W];
  assign wrd_a[0]     = in_prod[Q_W-1:0];
  assign len_a[0]     = in_len;
  assign ctl_a[0]     = in_ctl;
  assign rdy_a[STEPS] = out_rdy;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                  vld_r;
    logic [TICK_WIDTH-1:0] rem_r, rem_nxt;
    logic [Q_W-1:0]        wrd_r, wrd_nxt;
    logic [TICK_WIDTH-1:0] len_r;
    adsr_ctl_t             ctl_r;
    logic [TICK_WIDTH:0]   trial;
    logic [TICK_WIDTH:0]   diff;
    logic                  ge;
    logic                  en;

    assign en       = !vld_r || rdy_a[k+1];
    assign rdy_a[k] = en;

    // Bring down the next dividend bit and try a subtract.
    assign trial   = {rem_a[k], wrd_a[k][Q_W-1]};
    assign diff    = trial - {1'b0, len_a[k]};
    assign ge      = trial >= {1'b0, len_a[k]};
    assign rem_nxt = ge ? diff[TICK_WIDTH-1:0] : trial[TICK_WIDTH-1:0];
    assign wrd_nxt = {wrd_a[k][Q_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_a[k];
      end
      if (en && vld_a[k]) begin
        rem_r <= rem_nxt;
        wrd_r <= wrd_nxt;
        len_r <= len_a[k];
        ctl_r <= ctl_a[k];
      end
    end

    assign vld_a[k+1] = vld_r;
    assign rem_a[k+1] = rem_r;
    assign wrd_a[k+1] = wrd_r;
    assign len_a[k+1] = len_r;
    assign ctl_a[k+1] = ctl_r;
  end

  assign out_vld    = vld_a[STEPS];
  assign out_quo    = wrd_a[STEPS];
  assign out_rem_nz = rem_a[STEPS] != '0;
  assign out_ctl    = ctl_a[STEPS];

endmodule

`default_nettype wire

// ===== design/adsr_out.sv =====
// Envelope finish and gain scaling; the gain product register is the output register.
// Depends on adsr_pkg; takes the quotient from adsr_div.
`default_nettype none

module adsr_out (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_vld,
  output logic                           in_rdy,
  input  wire logic [adsr_pkg::Q_W-1:0]  in_quo,
  input  wire logic                      in_rem_nz,
  input  wire adsr_pkg::adsr_ctl_t       in_ctl,
  input  wire logic [adsr_pkg::Q_W-1:0]  gain,
  output logic                           out_vld,
  input  wire logic                      out_rdy,
  output logic [adsr_pkg::Q_W-1:0]       out_amp
);
  import adsr_pkg::*;

  logic               env_vld_r;
  logic [Q_W-1:0]     env_r, env_nxt;
  logic               prod_vld_r;
  logic [2*Q_W-1:0]   prod_r, prod_nxt;
  logic               env_en, prod_en;

  assign prod_en = !prod_vld_r || out_rdy;
  assign env_en  = !env_vld_r || prod_en;
  assign in_rdy  = env_en;

  // Fixed beats take the base as is; rising segments add the floor; falling ones take off the ceiling.
  always_comb begin
    if (in_ctl.fixed) begin
      env_nxt = in_ctl.base;
    end else if (in_ctl.down) begin
      env_nxt = in_ctl.base - in_quo - Q_W'(in_rem_nz);
    end else begin
      env_nxt = in_ctl.base + in_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_vld_r <= 1'b0;
    end else if (env_en) begin
      env_vld_r <= in_vld;
    end
    if (env_en && in_vld) begin
      env_r <= env_nxt;
    end
  end

  // Scale by gain; hold the product until the beat is taken.
  assign prod_nxt = {{Q_W{1'b0}}, env_r} * {{Q_W{1'b0}}, gain};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else if (prod_en) begin
      prod_vld_r <= env_vld_r;
    end
    if (prod_en && env_vld_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_vld = prod_vld_r;
  assign out_amp = prod_r[2*Q_W-2:Q_W-1];

endmodule

`default_nettype wire

// ===== design/adsr_envelope_amplitude.sv =====
// Top level of the linear ADSR envelope: config registers and the pipeline chain.
// Depends on adsr_pkg, adsr_seg, adsr_mul, adsr_div and adsr_out.
//
//   channel   direction  handshake            payload
//   in_       sink       in_valid / in_stall  in_note_released, in_elapsed_ticks
//   out_      source     out_valid/out_stall  out_amplitude
//   cfg_      sink       cfg_wr_en            cfg_index, cfg_wdata
//
// One beat enters per cycle while in_stall is low. Registers in order: capture, decode,
// product, one per quotient bit of the 16-stage divider, envelope finish, gain product.
// Reset (synchronous, rst_n low) empties the pipeline and loads the config defaults;
// there is no clearing pass. Bubbles collapse: in_stall rises only when every stage
// holds a beat and out_stall is high, and a stalled result holds in the output register.
`default_nettype none

module adsr_envelope_amplitude #(
  parameter int TICK_WIDTH = adsr_pkg::TICK_WIDTH_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  output logic                                          in_stall,
  input  wire logic                                     in_note_released,
  input  wire logic [TICK_WIDTH-1:0]                    in_elapsed_ticks,
  output logic                                          out_valid,
  input  wire logic                                     out_stall,
  output logic [adsr_pkg::Q_W-1:0]                      out_amplitude,
  input  wire logic                                     cfg_wr_en,
  input  wire logic [adsr_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [(TICK_WIDTH > adsr_pkg::Q_W ? TICK_WIDTH : adsr_pkg::Q_W)-1:0] cfg_wdata
);
  import adsr_pkg::*;

  localparam int PW = Q_W + TICK_WIDTH;

  logic [TICK_WIDTH-1:0] attack_r;
  logic [TICK_WIDTH-1:0] decay_r;
  logic [TICK_WIDTH-1:0] release_r;
  logic [Q_W-1:0]        sustain_r;
  logic [Q_W-1:0]        gain_r;
  logic [Q_W-1:0]        sus_sat;
  logic [Q_W-1:0]        gain_sat;

  logic                  seg_in_rdy;
  logic                  seg_vld, mul_rdy;
  logic [TICK_WIDTH-1:0] seg_ofs, seg_len;
  logic [Q_W-1:0]        seg_span;
  adsr_ctl_t             seg_ctl;

  logic                  mul_vld, div_rdy;
  logic [PW-1:0]         mul_prod;
  logic [TICK_WIDTH-1:0] mul_len;
  adsr_ctl_t             mul_ctl;

  logic                  div_vld, fin_rdy;
  logic [Q_W-1:0]        div_quo;
  logic                  div_rem_nz;
  adsr_ctl_t             div_ctl;

  // Config registers; writes to unused indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= TICK_WIDTH'(LEN_RESET);
      decay_r   <= TICK_WIDTH'(LEN_RESET);
      release_r <= TICK_WIDTH'(LEN_RESET);
      sustain_r <= Q_ONE;
      gain_r    <= Q_ONE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ATTACK:  attack_r  <= cfg_wdata[TICK_WIDTH-1:0];
        CFG_DECAY:   decay_r   <= cfg_wdata[TICK_WIDTH-1:0];
        CFG_RELEASE: release_r <= cfg_wdata[TICK_WIDTH-1:0];
        CFG_SUSTAIN: sustain_r <= cfg_wdata[Q_W-1:0];
        CFG_GAIN:    gain_r    <= cfg_wdata[Q_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp levels above 1.0.
  assign sus_sat  = sat_q(sustain_r);
  assign gain_sat = sat_q(gain_r);

  assign in_stall = !seg_in_rdy;

  adsr_seg #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_seg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (in_valid),
    .in_rdy      (seg_in_rdy),
    .in_released (in_note_released),
    .in_ticks    (in_elapsed_ticks),
    .attack_len  (attack_r),
    .decay_len   (decay_r),
    .release_len (release_r),
    .sus_lvl     (sus_sat),
    .out_vld     (seg_vld),
    .out_rdy     (mul_rdy),
    .out_ofs     (seg_ofs),
    .out_len     (seg_len),
    .out_span    (seg_span),
    .out_ctl     (seg_ctl)
  );

  adsr_mul #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (seg_vld),
    .in_rdy   (mul_rdy),
    .in_ofs   (seg_ofs),
    .in_len   (seg_len),
    .in_span  (seg_span),
    .in_ctl   (seg_ctl),
    .out_vld  (mul_vld),
    .out_rdy  (div_rdy),
    .out_prod (mul_prod),
    .out_len  (mul_len),
    .out_ctl  (mul_ctl)
  );

  adsr_div #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (mul_vld),
    .in_rdy     (div_rdy),
    .in_prod    (mul_prod),
    .in_len     (mul_len),
    .in_ctl     (mul_ctl),
    .out_vld    (div_vld),
    .out_rdy    (fin_rdy),
    .out_quo    (div_quo),
    .out_rem_nz (div_rem_nz),
    .out_ctl    (div_ctl)
  );

  adsr_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (div_vld),
    .in_rdy    (fin_rdy),
    .in_quo    (div_quo),
    .in_rem_nz (div_rem_nz),
    .in_ctl    (div_ctl),
    .gain      (gain_sat),
    .out_vld   (out_valid),
    .out_rdy   (!out_stall),
    .out_amp   (out_amplitude)
  );

endmodule

`default_nettype wire
